// ===== rtl/core/wmhv_pkg.sv =====
// Package for the WebAssembly module header validator.
// Holds parse phase types, error codes, header byte tables and the verdict struct.
// No dependencies; the parser, top level, checker and testbench import it.
`timescale 1ns / 1ps

package wmhv_pkg;

    localparam int unsigned HEADER_LEN   = 8;
    localparam int unsigned LEB_MAX_BYTES = 5;

    localparam logic [7:0] FUNC_MARKER  = 8'h60;
    localparam logic [7:0] TYPE_SECTION = 8'h01;
    localparam logic [7:0] CUSTOM_SECTION = 8'h00;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_SEC_ID    = 3'd1,
        PH_SEC_SIZE  = 3'd2,
        PH_SEC_BODY  = 3'd3,
        PH_TYPE_BODY = 3'd4,
        PH_FATAL     = 3'd5
    } parse_phase_t;

    typedef enum logic [2:0] {
        TP_COUNT  = 3'd0,
        TP_MARKER = 3'd1,
        TP_PCOUNT = 3'd2,
        TP_PSKIP  = 3'd3,
        TP_RCOUNT = 3'd4,
        TP_RSKIP  = 3'd5,
        TP_DONE   = 3'd6
    } type_phase_t;

    typedef enum logic [2:0] {
        FATAL_NONE       = 3'd0,
        FATAL_TOO_SMALL  = 3'd1,
        FATAL_BAD_MAGIC  = 3'd2,
        FATAL_ORDER      = 3'd3,
        FATAL_PAST_END   = 3'd4
    } fatal_code_t;

    typedef struct packed {
        logic        module_valid;
        logic [2:0]  fatal_error;
        logic        type_section_bad;
        logic        version_warning;
    } verdict_t;

    // Expected magic bytes 00 61 73 6D.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h00;
            2'd1:    val = 8'h61;
            2'd2:    val = 8'h73;
            default: val = 8'h6D;
        endcase
        return val;
    endfunction

    // Expected version bytes 01 00 00 00.
    function automatic logic [7:0] version_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/wmhv_ifs.sv =====
// Channel interfaces of the WebAssembly module header validator.
// Byte input, verdict output and the module length write channel.
// No dependencies.
`timescale 1ns / 1ps

interface wmhv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface wmhv_verdict_if;
    logic       valid;
    logic       ready;
    logic       module_valid;
    logic [2:0] fatal_error;
    logic       type_section_bad;
    logic       version_warning;

    modport source (output valid, output module_valid, output fatal_error,
                    output type_section_bad, output version_warning, input ready);
    modport sink   (input valid, input module_valid, input fatal_error,
                    input type_section_bad, input version_warning, output ready);
endinterface

interface wmhv_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] module_length;

    modport source (output valid, output module_length, input ready);
    modport sink   (input valid, input module_length, output ready);
endinterface

// ===== rtl/core/wmhv_parser.sv =====
// Byte parser of the WebAssembly module header validator: parse state registers
// and the next-state logic for one byte. Depends on wmhv_pkg.
`timescale 1ns / 1ps

module wmhv_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    input  logic [31:0]       module_length,
    output logic              result_flag,
    output wmhv_pkg::verdict_t result
);
    import wmhv_pkg::*;

    logic [31:0]  pos_reg, pos_next;
    parse_phase_t phase_reg, phase_next;
    logic [7:0]   hi_id_reg, hi_id_next;
    logic [7:0]   cur_id_reg, cur_id_next;
    logic [31:0]  acc_reg, acc_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [31:0]  sbl_reg, sbl_next;
    type_phase_t  tph_reg, tph_next;
    logic [31:0]  tel_reg, tel_next;
    logic [7:0]   skip_reg, skip_next;
    fatal_code_t  fatal_reg, fatal_next;
    logic         te_reg, te_next;
    logic         vm_reg, vm_next;

    logic         last;
    logic         leb_ends;
    logic         leb_room;
    logic [31:0]  leb_chunk;
    logic [31:0]  leb_or;
    logic [2:0]   cnt_take;
    logic [31:0]  acc_taken;
    logic [31:0]  tel_taken;
    logic [33:0]  sec_end;
    logic [31:0]  tel_dec;
    logic [7:0]   skip_dec;
    logic [31:0]  sbl_dec;
    fatal_code_t  fatal_fin;
    logic         te_fin;

    always_comb
    begin
        case (cnt_reg)
            3'd0:    leb_chunk = {25'd0, data_byte[6:0]};
            3'd1:    leb_chunk = {18'd0, data_byte[6:0], 7'd0};
            3'd2:    leb_chunk = {11'd0, data_byte[6:0], 14'd0};
            3'd3:    leb_chunk = {4'd0, data_byte[6:0], 21'd0};
            // Payload bits above bit 31 fall off the top.
            default: leb_chunk = {data_byte[3:0], 28'd0};
        endcase
    end

    always_comb
    begin
        last      = ({1'b0, pos_reg} + 33'd1) >= {1'b0, module_length};
        leb_ends  = ~data_byte[7];
        leb_room  = cnt_reg < 3'(LEB_MAX_BYTES);
        leb_or    = leb_room ? leb_chunk : 32'd0;
        cnt_take  = leb_ends ? 3'd0 : (leb_room ? cnt_reg + 3'd1 : cnt_reg);
        acc_taken = acc_reg | leb_or;
        tel_taken = tel_reg | leb_or;
        sec_end   = {2'b00, pos_reg} + 34'd1 + {2'b00, acc_taken};
        tel_dec   = tel_reg - 32'd1;
        skip_dec  = skip_reg - 8'd1;
        sbl_dec   = sbl_reg - 32'd1;

        pos_next    = pos_reg;
        phase_next  = phase_reg;
        hi_id_next  = hi_id_reg;
        cur_id_next = cur_id_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        sbl_next    = sbl_reg;
        tph_next    = tph_reg;
        tel_next    = tel_reg;
        skip_next   = skip_reg;
        fatal_next  = fatal_reg;
        te_next     = te_reg;
        vm_next     = vm_reg;

        case (phase_reg)
            PH_HEADER:
            begin
                if (module_length < 32'(HEADER_LEN))
                begin
                    fatal_next = FATAL_TOO_SMALL;
                    phase_next = PH_FATAL;
                end
                else if (pos_reg < 32'd4 && data_byte != magic_byte(pos_reg[1:0]))
                begin
                    fatal_next = FATAL_BAD_MAGIC;
                    phase_next = PH_FATAL;
                end
                else
                begin
                    if (pos_reg >= 32'd4 && data_byte != version_byte(pos_reg[1:0]))
                        vm_next = 1'b1;
                    if (pos_reg >= 32'(HEADER_LEN - 1))
                        phase_next = PH_SEC_ID;
                end
            end
            PH_SEC_ID:
            begin
                if (data_byte != CUSTOM_SECTION && data_byte <= hi_id_reg)
                begin
                    fatal_next = FATAL_ORDER;
                    phase_next = PH_FATAL;
                end
                else
                begin
                    if (data_byte != CUSTOM_SECTION)
                        hi_id_next = data_byte;
                    cur_id_next = data_byte;
                    acc_next    = 32'd0;
                    cnt_next    = 3'd0;
                    phase_next  = PH_SEC_SIZE;
                end
            end
            PH_SEC_SIZE:
            begin
                acc_next = acc_taken;
                cnt_next = cnt_take;
                if (leb_ends)
                begin
                    if (sec_end > {2'b00, module_length})
                    begin
                        fatal_next = FATAL_PAST_END;
                        phase_next = PH_FATAL;
                    end
                    else
                    begin
                        sbl_next = acc_taken;
                        if (acc_taken == 32'd0)
                        begin
                            if (cur_id_reg == TYPE_SECTION)
                                te_next = 1'b1;
                            phase_next = PH_SEC_ID;
                        end
                        else if (cur_id_reg == TYPE_SECTION)
                        begin
                            tph_next   = TP_COUNT;
                            tel_next   = 32'd0;
                            cnt_next   = 3'd0;
                            phase_next = PH_TYPE_BODY;
                        end
                        else
                        begin
                            phase_next = PH_SEC_BODY;
                        end
                    end
                end
            end
            PH_SEC_BODY, PH_TYPE_BODY:
            begin
                if (phase_reg == PH_TYPE_BODY)
                begin
                    case (tph_reg)
                        TP_COUNT:
                        begin
                            tel_next = tel_taken;
                            cnt_next = cnt_take;
                            if (leb_ends)
                                tph_next = (tel_taken != 32'd0) ? TP_MARKER : TP_DONE;
                        end
                        TP_MARKER:
                        begin
                            if (data_byte != FUNC_MARKER)
                            begin
                                te_next  = 1'b1;
                                tph_next = TP_DONE;
                            end
                            else
                            begin
                                tph_next = TP_PCOUNT;
                            end
                        end
                        TP_PCOUNT:
                        begin
                            skip_next = data_byte;
                            tph_next  = (data_byte != 8'd0) ? TP_PSKIP : TP_RCOUNT;
                        end
                        TP_PSKIP:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                                tph_next = TP_RCOUNT;
                        end
                        TP_RCOUNT:
                        begin
                            skip_next = data_byte;
                            if (data_byte != 8'd0)
                            begin
                                tph_next = TP_RSKIP;
                            end
                            else
                            begin
                                tel_next = tel_dec;
                                tph_next = (tel_dec != 32'd0) ? TP_MARKER : TP_DONE;
                            end
                        end
                        TP_RSKIP:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 8'd0)
                            begin
                                tel_next = tel_dec;
                                tph_next = (tel_dec != 32'd0) ? TP_MARKER : TP_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                sbl_next = sbl_dec;
                if (sbl_dec == 32'd0)
                    phase_next = PH_SEC_ID;
            end
            default:
            begin
            end
        endcase

        // A module that ends inside a section size is judged on the partial size.
        fatal_fin = fatal_next;
        te_fin    = te_next;
        if (phase_next == PH_SEC_SIZE)
        begin
            if (acc_next != 32'd0)
                fatal_fin = FATAL_PAST_END;
            else if (cur_id_next == TYPE_SECTION)
                te_fin = 1'b1;
        end

        result_flag             = last;
        result.module_valid     = (fatal_fin == FATAL_NONE) && !te_fin;
        result.fatal_error      = fatal_fin;
        result.type_section_bad = te_fin;
        result.version_warning  = vm_next;

        if (last)
        begin
            pos_next    = 32'd0;
            phase_next  = PH_HEADER;
            hi_id_next  = 8'd0;
            cur_id_next = 8'd0;
            acc_next    = 32'd0;
            cnt_next    = 3'd0;
            sbl_next    = 32'd0;
            tph_next    = TP_COUNT;
            tel_next    = 32'd0;
            skip_next   = 8'd0;
            fatal_next  = FATAL_NONE;
            te_next     = 1'b0;
            vm_next     = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 32'd0;
            phase_reg  <= PH_HEADER;
            hi_id_reg  <= 8'd0;
            cur_id_reg <= 8'd0;
            acc_reg    <= 32'd0;
            cnt_reg    <= 3'd0;
            sbl_reg    <= 32'd0;
            tph_reg    <= TP_COUNT;
            tel_reg    <= 32'd0;
            skip_reg   <= 8'd0;
            fatal_reg  <= FATAL_NONE;
            te_reg     <= 1'b0;
            vm_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            hi_id_reg  <= hi_id_next;
            cur_id_reg <= cur_id_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            sbl_reg    <= sbl_next;
            tph_reg    <= tph_next;
            tel_reg    <= tel_next;
            skip_reg   <= skip_next;
            fatal_reg  <= fatal_next;
            te_reg     <= te_next;
            vm_reg     <= vm_next;
        end
    end

endmodule

// ===== rtl/core/wasm_module_header_validator.sv =====
// Top level of the WebAssembly module header validator: input byte register,
// verdict register and module length register. Depends on wmhv_pkg, wmhv_ifs, wmhv_parser.
//
//   Channel   Direction  Payload                                   Beat
//   bytes     in         data_byte[7:0]                            one module byte
//   verdict   out        module_valid, fatal_error[2:0],           one verdict per module
//                        type_section_bad, version_warning
//   cfg       in         module_length[31:0]                       register write
//
// One byte per cycle sustained while verdicts are taken. A byte is held in the input
// register and parsed from there; if it ends a module, its verdict is registered on the
// same edge that the parser takes the byte. The parse state takes a whole byte per update.
// Reset clears all parse state and module_length to zero. A stalled verdict holds
// the parser, and the input register then fills and drops ready.
`timescale 1ns / 1ps

module wasm_module_header_validator (
    input  logic           clk,
    input  logic           rst_n,
    wmhv_byte_if.sink      bytes,
    wmhv_verdict_if.source verdict,
    wmhv_cfg_if.sink       cfg
);
    import wmhv_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        out_vld_reg;
    verdict_t    out_reg;
    logic [31:0] len_reg;

    logic        advance;
    logic        result_flag;
    verdict_t    result;

    assign advance     = in_vld_reg && (!out_vld_reg || verdict.ready);
    assign bytes.ready = !in_vld_reg || advance;
    assign cfg.ready   = 1'b1;

    wmhv_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .data_byte     (in_byte_reg),
        .module_length (len_reg),
        .result_flag   (result_flag),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            len_reg     <= 32'd0;
        end
        else
        begin
            if (bytes.valid && bytes.ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance && result_flag)
                out_vld_reg <= 1'b1;
            else if (verdict.ready)
                out_vld_reg <= 1'b0;

            if (cfg.valid)
                len_reg <= cfg.module_length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
            in_byte_reg <= bytes.data_byte;
        if (advance && result_flag)
            out_reg <= result;
    end

    assign verdict.valid            = out_vld_reg;
    assign verdict.module_valid     = out_reg.module_valid;
    assign verdict.fatal_error      = out_reg.fatal_error;
    assign verdict.type_section_bad = out_reg.type_section_bad;
    assign verdict.version_warning  = out_reg.version_warning;

endmodule

// ===== rtl/core/wmhv_checker.sv =====
// Port-level assertions for the WebAssembly module header validator, and the
// bind that attaches them to the top level. Depends on wmhv_pkg and the top level.
`timescale 1ns / 1ps

module wmhv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       module_valid,
    input logic [2:0] fatal_error,
    input logic       type_section_bad,
    input logic       version_warning
);
    import wmhv_pkg::*;

    // A verdict beat that is not taken stays with the same payload.
    a_verdict_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({module_valid, fatal_error, type_section_bad, version_warning}))
        else $error("verdict changed while stalled");

    // The overall flag agrees with the detailed fields.
    a_valid_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> module_valid == (fatal_error == 3'(FATAL_NONE) && !type_section_bad))
        else $error("module_valid disagrees with error fields");

    a_fatal_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> fatal_error <= 3'(FATAL_PAST_END))
        else $error("fatal_error out of range");

    // The version bytes are never checked when the magic number failed.
    a_no_version_on_header_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fatal_error == 3'(FATAL_BAD_MAGIC) |-> !version_warning)
        else $error("version warning after header failure");

endmodule

bind wasm_module_header_validator wmhv_checker u_wmhv_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (verdict.valid),
    .out_ready        (verdict.ready),
    .module_valid     (verdict.module_valid),
    .fatal_error      (verdict.fatal_error),
    .type_section_bad (verdict.type_section_bad),
    .version_warning  (verdict.version_warning)
);

// ===== verif/tb_wasm_module_header_validator.sv =====
// Self-checking testbench for wasm_module_header_validator.
// Streams module images byte by byte, predicts each verdict and compares it field by field.
// Depends on wmhv_pkg, the wmhv channel interfaces and the validator RTL.
`timescale 1ns / 1ps

module tb_wasm_module_header_validator;

    import wmhv_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_PRINTED = 40;

    // Header bytes, first byte in the low lane.
    localparam logic [31:0] MAGIC_WORD = 32'h6D73_6100;
    localparam logic [31:0] VERSION_WORD = 32'h0000_0001;

    logic clk;
    logic rst_n;

    wmhv_byte_if byte_ch();
    wmhv_verdict_if verdict_ch();
    wmhv_cfg_if cfg_ch();

    wasm_module_header_validator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .verdict (verdict_ch),
        .cfg     (cfg_ch)
    );

    // Stimulus and scoreboard state.
    logic [7:0] byte_feed[$];
    logic [7:0] image_q[$];
    logic [7:0] body_q[$];
    verdict_t expected_verdicts[$];
    int unsigned bytes_queued;
    int unsigned bytes_taken;
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    bit hold_start;
    logic hold_off;

    // Predicted parser state.
    logic [31:0] mod_len;
    logic [31:0] byte_pos;
    parse_phase_t phase;
    logic [7:0] seen_max_id;
    logic [7:0] sec_id;
    logic [31:0] size_val;
    logic [2:0] leb_idx;
    logic [31:0] body_left;
    type_phase_t tphase;
    logic [31:0] entries_due;
    logic [7:0] skip_due;
    fatal_code_t fatal_now;
    logic type_flag;
    logic version_flag;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------------- predictor

    function automatic void reset_parse();
        byte_pos = '0;
        phase = PH_HEADER;
        seen_max_id = '0;
        sec_id = '0;
        size_val = '0;
        leb_idx = '0;
        body_left = '0;
        tphase = TP_COUNT;
        entries_due = '0;
        skip_due = '0;
        fatal_now = FATAL_NONE;
        type_flag = 1'b0;
        version_flag = 1'b0;
    endfunction

    function automatic void raise_fatal(input fatal_code_t code);
        fatal_now = code;
        phase = PH_FATAL;
    endfunction

    // Payload beyond the fifth LEB byte is dropped, and so is anything above bit 31.
    function automatic logic [31:0] leb_merge(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] merged;
        merged = acc;
        if (leb_idx < LEB_MAX_BYTES)
        begin
            merged = acc | ({25'd0, b[6:0]} << (7 * leb_idx));
            leb_idx = leb_idx + 3'd1;
        end
        if (!b[7])
            leb_idx = '0;
        return merged;
    endfunction

    function automatic void close_size();
        logic [32:0] stop;
        stop = {1'b0, byte_pos} + 33'd1 + {1'b0, size_val};
        if (stop > {1'b0, mod_len})
            raise_fatal(FATAL_PAST_END);
        else
        begin
            body_left = size_val;
            if (size_val == 0)
            begin
                if (sec_id == TYPE_SECTION)
                    type_flag = 1'b1;
                phase = PH_SEC_ID;
            end
            else if (sec_id == TYPE_SECTION)
            begin
                tphase = TP_COUNT;
                entries_due = '0;
                leb_idx = '0;
                phase = PH_TYPE_BODY;
            end
            else
                phase = PH_SEC_BODY;
        end
    endfunction

    function automatic void type_body_byte(input logic [7:0] b);
        bit advance;
        advance = 1'b0;
        case (tphase)
            TP_COUNT:
            begin
                entries_due = leb_merge(entries_due, b);
                if (!b[7])
                    tphase = (entries_due != 0) ? TP_MARKER : TP_DONE;
            end
            TP_MARKER:
            begin
                if (b != FUNC_MARKER)
                begin
                    type_flag = 1'b1;
                    tphase = TP_DONE;
                end
                else
                    tphase = TP_PCOUNT;
            end
            TP_PCOUNT, TP_RCOUNT:
            begin
                skip_due = b;
                if (b != 0)
                    tphase = type_phase_t'(tphase + 3'd1);
                else
                    advance = 1'b1;
            end
            TP_PSKIP, TP_RSKIP:
            begin
                skip_due = skip_due - 8'd1;
                advance = (skip_due == 0);
            end
            default:
                ;
        endcase
        // A finished count list moves on to the results, a finished result list to the next entry.
        if (advance)
        begin
            if (tphase == TP_PCOUNT || tphase == TP_PSKIP)
                tphase = TP_RCOUNT;
            else
            begin
                entries_due = entries_due - 1;
                tphase = (entries_due != 0) ? TP_MARKER : TP_DONE;
            end
        end
    endfunction

    // Returns 1 when this byte ends the module, with the verdict in v.
    function automatic bit parse_byte(input logic [7:0] b, output verdict_t v);
        bit last;
        last = ({1'b0, byte_pos} + 33'd1) >= {1'b0, mod_len};
        v = '0;
        case (phase)
            PH_HEADER:
            begin
                if (mod_len < HEADER_LEN)
                    raise_fatal(FATAL_TOO_SMALL);
                else if (byte_pos < 4 && b != MAGIC_WORD[8 * byte_pos[1:0] +: 8])
                    raise_fatal(FATAL_BAD_MAGIC);
                else
                begin
                    if (byte_pos >= 4 && b != VERSION_WORD[8 * byte_pos[1:0] +: 8])
                        version_flag = 1'b1;
                    if (byte_pos >= HEADER_LEN - 1)
                        phase = PH_SEC_ID;
                end
            end
            PH_SEC_ID:
            begin
                if (b != CUSTOM_SECTION && b <= seen_max_id)
                    raise_fatal(FATAL_ORDER);
                else
                begin
                    if (b != CUSTOM_SECTION)
                        seen_max_id = b;
                    sec_id = b;
                    size_val = '0;
                    leb_idx = '0;
                    phase = PH_SEC_SIZE;
                end
            end
            PH_SEC_SIZE:
            begin
                size_val = leb_merge(size_val, b);
                if (!b[7])
                    close_size();
            end
            PH_SEC_BODY, PH_TYPE_BODY:
            begin
                if (phase == PH_TYPE_BODY)
                    type_body_byte(b);
                body_left = body_left - 1;
                if (body_left == 0)
                    phase = PH_SEC_ID;
            end
            default:
                ;
        endcase

        if (!last)
        begin
            byte_pos = byte_pos + 1;
            return 1'b0;
        end
        // A module cut inside a size field is judged on the partial value.
        if (phase == PH_SEC_SIZE)
        begin
            if (size_val != 0)
                raise_fatal(FATAL_PAST_END);
            else if (sec_id == TYPE_SECTION)
                type_flag = 1'b1;
        end
        v.module_valid = (fatal_now == FATAL_NONE) && !type_flag;
        v.fatal_error = fatal_now;
        v.type_section_bad = type_flag;
        v.version_warning = version_flag;
        reset_parse();
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        verdict_t v;
        if (!rst_n)
        begin
            mod_len = '0;
            reset_parse();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                mod_len = cfg_ch.module_length;
            if (byte_ch.valid && byte_ch.ready)
            begin
                bytes_taken++;
                if (parse_byte(byte_ch.data_byte, v))
                    expected_verdicts = {expected_verdicts, v};
            end
        end
    end

    // ---------------------------------------------------------------- driver and monitor

    always @(posedge clk)
    begin
        if (!rst_n)
            byte_ch.valid <= 1'b0;
        else if (!byte_ch.valid || byte_ch.ready)
        begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                byte_ch.valid <= 1'b1;
                byte_ch.data_byte <= byte_feed.pop_front();
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (!rst_n)
            verdict_ch.ready <= 1'b0;
        else
        begin
            verdict_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
            if (verdict_ch.valid && verdict_ch.ready)
            begin
                if (expected_verdicts.size() == 0)
                    flag_mismatch("verdict beat with none pending", 1, 0);
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict_ch.module_valid !== want.module_valid)
                        flag_mismatch("module_valid", verdict_ch.module_valid,
                                      want.module_valid);
                    if (verdict_ch.fatal_error !== want.fatal_error)
                        flag_mismatch("fatal_error", verdict_ch.fatal_error,
                                      want.fatal_error);
                    if (verdict_ch.type_section_bad !== want.type_section_bad)
                        flag_mismatch("type_section_bad", verdict_ch.type_section_bad,
                                      want.type_section_bad);
                    if (verdict_ch.version_warning !== want.version_warning)
                        flag_mismatch("version_warning", verdict_ch.version_warning,
                                      want.version_warning);
                end
            end
        end
    end

    // Long receiver hold-off so the verdict path backs up into the byte input.
    initial
    begin
        hold_off = 1'b0;
        wait (hold_start);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic set_pace(input int unsigned mode);
        case (mode)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 53; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 53; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
        endcase
    endtask

    task automatic await_idle();
        while (bytes_taken != bytes_queued || expected_verdicts.size() != 0)
            @(posedge clk);
        // Bytes that end no module may still be in the parser.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [31:0] len);
        await_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.module_length <= len;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic feed(input logic [7:0] b);
        byte_feed = {byte_feed, b};
        bytes_queued++;
    endtask

    // Section size as LEB128, sometimes padded with extra continuation bytes whose payload is zero or ignored.
    function automatic void put_leb(input logic [31:0] value, input bit padded);
        int unsigned width;
        int unsigned k;
        logic [7:0] b;
        logic [2:0] junk;
        width = 1;
        while (width < 5 && (value >> (7 * width)) != 0)
            width++;
        if (padded)
            width = width + $urandom_range(1, 3);
        for (k = 0; k < width; k++)
        begin
            junk = 3'($urandom_range(7));
            if (k < 4)
                b = {1'b0, value[7 * k +: 7]};
            else if (k == 4)
                b = {1'b0, junk, value[31:28]};
            else
                b = 8'($urandom_range(127));
            if (k != width - 1)
                b[7] = 1'b1;
            image_q = {image_q, b};
        end
    endfunction

    function automatic void build_type_body();
        int unsigned count;
        int unsigned e;
        int unsigned k;
        int unsigned n;
        count = $urandom_range(0, 3);
        if ($urandom_range(99) < 20)
        begin
            body_q = {body_q, 8'h80 | 8'(count)};
            body_q = {body_q, 8'h00};
        end
        else
            body_q = {body_q, 8'(count)};
        for (e = 0; e < count; e++)
        begin
            if ($urandom_range(99) < 92)
                body_q = {body_q, FUNC_MARKER};
            else
                body_q = {body_q, 8'($urandom_range(255))};
            n = $urandom_range(0, 3);
            body_q = {body_q, 8'(n)};
            for (k = 0; k < n; k++)
                body_q = {body_q, 8'($urandom_range(8'h7C, 8'h7F))};
            n = $urandom_range(0, 2);
            body_q = {body_q, 8'(n)};
            for (k = 0; k < n; k++)
                body_q = {body_q, 8'($urandom_range(8'h7C, 8'h7F))};
        end
    endfunction

    // Builds one module image for the current length and feeds its first keep bytes
    // (all of it when keep is 0). Mostly well formed, with damage mixed in.
    task automatic queue_module(input int unsigned len, input int unsigned keep);
        int unsigned full;
        int unsigned k;
        int unsigned room;
        int unsigned roll;
        int unsigned id;
        int unsigned top_id;
        int unsigned size;
        int unsigned filler;
        full = (len == 0) ? 1 : len;
        if (keep == 0 || keep > full)
            keep = full;
        image_q.delete();
        if (len < HEADER_LEN || $urandom_range(99) < 8)
        begin
            for (k = 0; k < full; k++)
                image_q = {image_q, 8'($urandom_range(255))};
        end
        else
        begin
            for (k = 0; k < 4; k++)
                image_q = {image_q, MAGIC_WORD[8 * k +: 8]};
            for (k = 0; k < 4; k++)
                image_q = {image_q, VERSION_WORD[8 * k +: 8]};
            if ($urandom_range(99) < 8)
            begin
                k = $urandom_range(3);
                image_q[k] = image_q[k] ^ 8'($urandom_range(1, 255));
            end
            if ($urandom_range(99) < 15)
            begin
                k = $urandom_range(4, 7);
                image_q[k] = image_q[k] ^ 8'($urandom_range(1, 255));
            end
            top_id = 0;
            while (image_q.size() < len)
            begin
                room = len - image_q.size();
                roll = $urandom_range(99);
                if (roll < 12)
                    id = CUSTOM_SECTION;
                else if (roll < 18)
                    id = $urandom_range(255);
                else if (top_id == 0 && roll < 70)
                    id = TYPE_SECTION;
                else
                    id = top_id + $urandom_range(1, 3);
                if (id > 255)
                    id = CUSTOM_SECTION;
                if (id > top_id)
                    top_id = id;

                body_q.delete();
                if (id == TYPE_SECTION)
                    build_type_body();
                else
                begin
                    filler = (room > 3) ? $urandom_range(0, (room - 3 < 12) ? room - 3 : 12) : 0;
                    for (k = 0; k < filler; k++)
                        body_q = {body_q, 8'($urandom_range(255))};
                end

                roll = $urandom_range(99);
                if (roll < 80)
                    size = body_q.size();
                else if (roll < 90)
                    size = $urandom_range(0, body_q.size() + 3);
                else if (roll < 96)
                    size = room + $urandom_range(0, 4);
                else
                    size = $urandom();

                image_q = {image_q, 8'(id)};
                put_leb(size, $urandom_range(99) < 15);
                for (k = 0; k < body_q.size() && k < size; k++)
                    image_q = {image_q, body_q[k]};
                while (k < size && image_q.size() < len)
                begin
                    image_q = {image_q, 8'($urandom_range(255))};
                    k++;
                end
            end
        end
        for (k = 0; k < keep; k++)
            feed(image_q[k]);
    endtask

    initial
    begin
        int unsigned phase_no;
        int unsigned len;
        int unsigned roll;
        int unsigned cut;
        int unsigned phase_bytes;
        int unsigned rand_bytes;
        int unsigned rand_modules;

        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        verdict_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.module_length = '0;
        bytes_queued = 0;
        bytes_taken = 0;
        error_count = 0;
        cycle_count = 0;
        hold_start = 1'b0;
        set_pace(0);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Zero length: each byte is a module of its own, judged too small.
        write_length(32'd0);
        feed(8'h00); feed(8'hFF);

        // Longest length: a clean type section behind a seven-byte size, then a section
        // whose size needs all 32 bits. The length is cut down mid-module afterwards.
        write_length(32'hFFFF_FFFF);
        feed(8'h00); feed(8'h61); feed(8'h73); feed(8'h6D);
        feed(8'h01); feed(8'h00); feed(8'h00); feed(8'h00);
        feed(TYPE_SECTION);
        feed(8'h85); feed(8'h80); feed(8'h80); feed(8'h80); feed(8'hF0); feed(8'h80); feed(8'h00);
        feed(8'h01); feed(FUNC_MARKER); feed(8'h01); feed(8'h7F); feed(8'h00);
        feed(8'h0A);
        feed(8'h80); feed(8'h80); feed(8'h80); feed(8'h80); feed(8'h0F);
        feed(8'h55);
        write_length(32'd8);
        feed(8'hAA);

        // Odd version, then the module ends inside the type section's size.
        write_length(32'd10);
        feed(8'h00); feed(8'h61); feed(8'h73); feed(8'h6D);
        feed(8'h02); feed(8'h00); feed(8'h00); feed(8'h00);
        feed(TYPE_SECTION); feed(8'h80);

        // Receiver holds off while short modules keep coming.
        write_length(32'd9);
        hold_start = 1'b1;
        repeat (8) queue_module(9, 0);

        phase_no = 0;
        rand_bytes = 0;
        rand_modules = 0;
        while (rand_bytes < 600 || rand_modules < 50)
        begin
            roll = $urandom_range(99);
            if (roll < 12)
                len = $urandom_range(0, 7);
            else if (roll < 85)
                len = $urandom_range(8, 40);
            else
                len = $urandom_range(41, 96);
            write_length(len);
            set_pace(phase_no % 4);
            phase_bytes = 0;
            while (phase_bytes < 60)
            begin
                queue_module(len, 0);
                phase_bytes += (len == 0) ? 1 : len;
                rand_modules++;
            end
            // Leave a module unfinished so the next length write lands mid-module.
            if (len > 1 && $urandom_range(99) < 20)
            begin
                cut = $urandom_range(1, len - 1);
                queue_module(len, cut);
                phase_bytes += cut;
            end
            rand_bytes += phase_bytes;
            phase_no++;
        end

        await_idle();
        if (expected_verdicts.size() != 0)
            flag_mismatch("verdicts never delivered", 0, expected_verdicts.size());
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== wasm_module_header_validator.f =====
rtl/core/wmhv_pkg.sv
rtl/core/wmhv_ifs.sv
rtl/core/wmhv_parser.sv
rtl/core/wasm_module_header_validator.sv
rtl/core/wmhv_checker.sv
verif/tb_wasm_module_header_validator.sv
